/* rtl/safer_pkg.sv */
// Shared constants, tables and round functions for the SAFER block cipher.
package safer_pkg;

    // Number of rounds per key schedule
    localparam int NR = 13;
    // Subkey words per key
    localparam int SCHED_WORDS = 2 * NR + 1;
    // Round stages for three chained passes
    localparam int STAGES = 3 * NR;
    // Bytes that take xor in the key add (bytes 0, 3, 4, 7)
    localparam logic [7:0] XG_MASK = 8'b1001_1001;

    // Configuration register indexes
    localparam logic [2:0] REG_TYPE   = 3'd6;
    localparam logic [2:0] REG_TRIPLE = 3'd7;

    typedef logic [7:0] tab_t [256];
    typedef logic [2:0][SCHED_WORDS-1:0][63:0] sched_t;
    typedef logic [7:0] bytes_t [8];

    // 45^x mod 257, with 256 stored as 0
    function automatic tab_t exp_build();
        tab_t t;
        int   e;
        e = 1;
        for (int l = 0; l < 256; l++)
        begin
            t[l] = e[7:0];
            e = (e * 45) % 257;
        end
        return t;
    endfunction

    // Inverse of the exp table
    function automatic tab_t log_build();
        tab_t t;
        int   e;
        e = 1;
        for (int l = 0; l < 256; l++)
        begin
            t[e[7:0]] = l[7:0];
            e = (e * 45) % 257;
        end
        return t;
    endfunction

    localparam tab_t EXP_TAB = exp_build();
    localparam tab_t LOG_TAB = log_build();

    function automatic bytes_t unpack_w(input logic [63:0] w);
        bytes_t b;
        for (int i = 0; i < 8; i++)
        begin
            b[i] = w[63-8*i -: 8];
        end
        return b;
    endfunction

    function automatic logic [63:0] pack_w(input bytes_t b);
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
        begin
            w[63-8*i -: 8] = b[i];
        end
        return w;
    endfunction

    // One encryption round, with the output whitening when last is set
    function automatic logic [63:0] enc_round(input logic [63:0] w, input logic [63:0] ka,
                                              input logic [63:0] kb, input logic [63:0] kf,
                                              input logic last);
        bytes_t x;
        bytes_t a;
        bytes_t b;
        bytes_t f;
        bytes_t y;
        x = unpack_w(w);
        a = unpack_w(ka);
        b = unpack_w(kb);
        f = unpack_w(kf);
        for (int j = 0; j < 8; j++)
        begin
            if (XG_MASK[j])
            begin
                x[j] = EXP_TAB[x[j] ^ a[j]] + b[j];
            end
            else
            begin
                x[j] = LOG_TAB[8'(x[j] + a[j])] ^ b[j];
            end
        end
        // three PHT layers
        for (int j = 0; j < 8; j += 2)
        begin
            x[j+1] = x[j+1] + x[j]; x[j] = x[j] + x[j+1];
        end
        for (int j = 0; j < 8; j++)
        begin
            if ((j % 4) < 2)
            begin
                x[j+2] = x[j+2] + x[j]; x[j] = x[j] + x[j+2];
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            x[j+4] = x[j+4] + x[j]; x[j] = x[j] + x[j+4];
        end
        // byte shuffle
        y[0] = x[0]; y[1] = x[4]; y[2] = x[1]; y[3] = x[5];
        y[4] = x[2]; y[5] = x[6]; y[6] = x[3]; y[7] = x[7];
        if (last)
        begin
            for (int j = 0; j < 8; j++)
            begin
                y[j] = XG_MASK[j] ? (y[j] ^ f[j]) : 8'(y[j] + f[j]);
            end
        end
        return pack_w(y);
    endfunction

    // One decryption round, with the input whitening removed when first is set
    function automatic logic [63:0] dec_round(input logic [63:0] w, input logic [63:0] ka,
                                              input logic [63:0] kb, input logic [63:0] kf,
                                              input logic first);
        bytes_t x;
        bytes_t a;
        bytes_t b;
        bytes_t f;
        bytes_t y;
        x = unpack_w(w);
        a = unpack_w(ka);
        b = unpack_w(kb);
        f = unpack_w(kf);
        if (first)
        begin
            for (int j = 0; j < 8; j++)
            begin
                x[j] = XG_MASK[j] ? (x[j] ^ f[j]) : 8'(x[j] - f[j]);
            end
        end
        // undo the byte shuffle
        y[0] = x[0]; y[1] = x[2]; y[2] = x[4]; y[3] = x[6];
        y[4] = x[1]; y[5] = x[3]; y[6] = x[5]; y[7] = x[7];
        for (int j = 0; j < 4; j++)
        begin
            y[j] = y[j] - y[j+4]; y[j+4] = y[j+4] - y[j];
        end
        for (int j = 0; j < 8; j++)
        begin
            if ((j % 4) < 2)
            begin
                y[j] = y[j] - y[j+2]; y[j+2] = y[j+2] - y[j];
            end
        end
        for (int j = 0; j < 8; j += 2)
        begin
            y[j] = y[j] - y[j+1]; y[j+1] = y[j+1] - y[j];
        end
        for (int j = 0; j < 8; j++)
        begin
            if (XG_MASK[j])
            begin
                y[j] = LOG_TAB[8'(y[j] - b[j])] ^ a[j];
            end
            else
            begin
                y[j] = EXP_TAB[y[j] ^ b[j]] - a[j];
            end
        end
        return pack_w(y);
    endfunction

endpackage

/* rtl/safer_ks.sv */
// Key schedule expander: builds the subkeys of all three keys, two words a cycle.
module safer_ks (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  restart,
    input  logic [5:0][63:0]      key_words,
    input  logic [1:0]            cipher_type,
    output safer_pkg::sched_t     sched,
    output logic                  ready
);

    logic [7:0]  a_reg [9];
    logic [7:0]  b_reg [9];
    logic [7:0]  a_next [9];
    logic [7:0]  b_next [9];
    logic [1:0]  key_reg;
    logic [3:0]  step_reg;
    logic [3:0]  offa_reg;
    logic [3:0]  offb_reg;
    logic        ready_reg;
    safer_pkg::sched_t sched_reg;
    logic [63:0] k1;
    logic [63:0] k2;
    logic [63:0] sub_a;
    logic [63:0] sub_b;
    logic        sk;

    assign sk    = cipher_type[0];
    assign sched = sched_reg;
    assign ready = ready_reg;

    // key halves for the current key
    always_comb
    begin
        if (cipher_type[1])
        begin
            k1 = key_words[{key_reg, 1'b0}];
            k2 = key_words[{key_reg, 1'b1}];
        end
        else
        begin
            k1 = key_words[key_reg];
            k2 = key_words[key_reg];
        end
    end

    // rotated registers and the two subkey words of this step
    always_comb
    begin
        logic [4:0] ia;
        logic [4:0] ib;
        logic [7:0] idx;
        for (int j = 0; j < 9; j++)
        begin
            a_next[j] = {a_reg[j][1:0], a_reg[j][7:2]};
            b_next[j] = {b_reg[j][1:0], b_reg[j][7:2]};
        end
        for (int j = 0; j < 8; j++)
        begin
            ia = 5'(offa_reg) + 5'(j);
            ib = 5'(offb_reg) + 5'(j);
            if (ia >= 5'd9) ia = ia - 5'd9;
            if (ib >= 5'd9) ib = ib - 5'd9;
            idx = 8'(8'd18 * {4'd0, step_reg}) + 8'(j + 1);
            sub_a[63-8*j -: 8] = (sk ? a_next[ia[3:0]] : a_next[j])
                                 + safer_pkg::EXP_TAB[safer_pkg::EXP_TAB[idx]];
            idx = 8'(8'd18 * {4'd0, step_reg}) + 8'(j + 10);
            sub_b[63-8*j -: 8] = (sk ? b_next[ib[3:0]] : b_next[j])
                                 + safer_pkg::EXP_TAB[safer_pkg::EXP_TAB[idx]];
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            step_reg  <= '0;
            offa_reg  <= '0;
            offb_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else if (restart)
        begin
            key_reg   <= '0;
            step_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else if (!ready_reg)
        begin
            if (step_reg == '0)
            begin
                step_reg <= 4'd1;
                offa_reg <= 4'd1;
                offb_reg <= 4'd2;
            end
            else
            begin
                offa_reg <= (offa_reg >= 4'd7) ? offa_reg - 4'd7 : offa_reg + 4'd2;
                offb_reg <= (offb_reg >= 4'd7) ? offb_reg - 4'd7 : offb_reg + 4'd2;
                if (step_reg == 4'(safer_pkg::NR))
                begin
                    step_reg <= '0;
                    if (key_reg == 2'd2)
                    begin
                        ready_reg <= 1'b1;
                    end
                    else
                    begin
                        key_reg <= key_reg + 2'd1;
                    end
                end
                else
                begin
                    step_reg <= step_reg + 4'd1;
                end
            end
        end
    end

    // rotating key bytes and the subkey words
    always_ff @(posedge clk)
    begin
        if (!restart && !ready_reg)
        begin
            if (step_reg == '0)
            begin
                for (int j = 0; j < 8; j++)
                begin
                    a_reg[j] <= {k1[58-8*j -: 3], k1[63-8*j -: 5]};
                    b_reg[j] <= k2[63-8*j -: 8];
                end
                a_reg[8] <= {k1[58 -: 3], k1[63 -: 5]} ^ {k1[50 -: 3], k1[55 -: 5]}
                          ^ {k1[42 -: 3], k1[47 -: 5]} ^ {k1[34 -: 3], k1[39 -: 5]}
                          ^ {k1[26 -: 3], k1[31 -: 5]} ^ {k1[18 -: 3], k1[23 -: 5]}
                          ^ {k1[10 -: 3], k1[15 -: 5]} ^ {k1[2 -: 3], k1[7 -: 5]};
                b_reg[8] <= k2[63:56] ^ k2[55:48] ^ k2[47:40] ^ k2[39:32]
                          ^ k2[31:24] ^ k2[23:16] ^ k2[15:8] ^ k2[7:0];
                sched_reg[key_reg][0] <= k2;
            end
            else
            begin
                a_reg <= a_next;
                b_reg <= b_next;
                sched_reg[key_reg][5'({step_reg, 1'b0} - 5'd1)] <= sub_a;
                sched_reg[key_reg][5'({step_reg, 1'b0})]        <= sub_b;
            end
        end
    end

endmodule

/* rtl/safer_block_cipher_top.sv */
// Top level of the SAFER block cipher: configuration, round pipeline and output.
//
// SAFER K-64 / SK-64 / K-128 / SK-128 block cipher, ECB, single or triple.
// Input words arrive on s_tvalid/s_tready: s_tdata carries the 64-bit block
// (byte 0 in the top byte), s_tuser selects encrypt (0) or decrypt (1).
// Results leave on m_tvalid/m_tready with the 64-bit block in m_tdata.
// Keys, cipher type and triple mode are written through cfg_we/cfg_idx/cfg_data
// while the block is idle, which the user must ensure; the block has no check.
// Any write restarts the key schedule, which is built key by key after reset or
// after the last configuration write; s_tready stays low until it is done.
// The datapath is a pipeline of 39 round stages (three passes of 13 rounds);
// single mode passes the word through the last 26 stages unchanged.
// Words move through the stages in order; one word is accepted per cycle
// while the output is not stalled. When m_tready is low with a word waiting,
// the whole pipeline holds and s_tready drops; nothing is lost or repeated.
// Reset clears the valid bits, the configuration (all zero) and the schedule ready flag.
module safer_block_cipher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // data_block[63:0]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_block[63:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [63:0] cfg_data
);

    localparam int NS = safer_pkg::STAGES;
    localparam int NW = safer_pkg::SCHED_WORDS;

    logic [5:0][63:0]  key_word_reg;
    logic [1:0]        type_reg;
    logic              triple_reg;
    safer_pkg::sched_t sched;
    logic              sched_ready;
    logic              adv;

    logic              stg_vld_reg [NS];
    logic              stg_dec_reg [NS];
    logic [63:0]       stg_dat_reg [NS];
    logic [63:0]       stg_dat_next [NS];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_word_reg <= '0;
            type_reg     <= '0;
            triple_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == safer_pkg::REG_TYPE)
            begin
                type_reg <= cfg_data[1:0];
            end
            else if (cfg_idx == safer_pkg::REG_TRIPLE)
            begin
                triple_reg <= cfg_data[0];
            end
            else
            begin
                key_word_reg[cfg_idx] <= cfg_data;
            end
        end
    end

    safer_ks u_ks (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (cfg_we),
        .key_words   (key_word_reg),
        .cipher_type (type_reg),
        .sched       (sched),
        .ready       (sched_ready)
    );

    // global advance: hold everything while the output word waits
    assign adv      = !stg_vld_reg[NS-1] || m_tready;
    assign s_tready = sched_ready && adv;
    assign m_tvalid = stg_vld_reg[NS-1];
    assign m_tdata  = stg_dat_reg[NS-1];

    // round stages
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam int P = s / safer_pkg::NR;
        localparam int R = s % safer_pkg::NR;
        localparam int DR = safer_pkg::NR - 1 - R;
        logic [63:0] din;
        logic        ddec;
        logic [1:0]  dq;

        if (s == 0)
        begin : g_first
            assign din  = s_tdata;
            assign ddec = s_tuser;
        end
        else
        begin : g_rest
            assign din  = stg_dat_reg[s-1];
            assign ddec = stg_dec_reg[s-1];
        end

        // decryption walks the keys backwards in triple mode
        assign dq = triple_reg ? 2'(2 - P) : 2'd0;

        always_comb
        begin
            if (P != 0 && !triple_reg)
            begin
                stg_dat_next[s] = din;
            end
            else if (ddec)
            begin
                stg_dat_next[s] = safer_pkg::dec_round(din, sched[dq][2*DR],
                                                       sched[dq][2*DR+1],
                                                       sched[dq][NW-1], R == 0);
            end
            else
            begin
                stg_dat_next[s] = safer_pkg::enc_round(din, sched[P][2*R],
                                                       sched[P][2*R+1],
                                                       sched[P][NW-1],
                                                       R == safer_pkg::NR - 1);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                if (s == 0)
                begin
                    stg_vld_reg[s] <= s_tvalid && sched_ready;
                end
                else
                begin
                    stg_vld_reg[s] <= stg_vld_reg[s-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stg_dat_reg[s] <= stg_dat_next[s];
                stg_dec_reg[s] <= ddec;
            end
        end
    end

    // no word enters before the schedule is complete
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> sched_ready)
        else $error("input taken with schedule not ready");

    // a configuration write invalidates the schedule
    assert property (@(posedge clk) disable iff (!rst_n) cfg_we |=> !sched_ready)
        else $error("schedule still ready after configuration write");

    // an accepted word enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
                     s_tvalid && s_tready |=> stg_vld_reg[0])
        else $error("accepted word lost at pipeline entry");

    // a stalled output keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
                     stg_vld_reg[NS-1] && !m_tready |=> stg_vld_reg[NS-1])
        else $error("pipeline advanced while output stalled");

endmodule
